// ----- design/format_string_expander_assert.svh -----
// Assertion macros shared by the checker of the format string expander.
`ifndef FORMAT_STRING_EXPANDER_ASSERT_SVH
`define FORMAT_STRING_EXPANDER_ASSERT_SVH
// Implication in the same cycle.
`define FSE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication in the next cycle.
`define FSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/fse_pkg.sv -----
// Shared types, character codes and lookup functions of the format string expander.
package fse_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int ARG_W      = 64;
  localparam int STEP_W     = $clog2(ARG_W);
  localparam int LIT_N      = 3;
  localparam int LITC_W     = 2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
    logic sel_digit;
    logic last;
    logic dabble;
    logic skip;
    logic finish;
  } fse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lit_left;
    logic lit_one;
    logic num;
    logic hex;
    logic dab_done;
    logic digit_zero;
    logic idx_zero;
  } fse_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- design/fse_in_if.sv -----
// Request channel carrying pattern bytes and argument words.
interface fse_in_if;
  import fse_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        pattern_byte;
  logic [ARG_W-1:0]  argument_value;
  modport source (output valid, command, pattern_byte, argument_value, input ready);
  modport sink (input valid, command, pattern_byte, argument_value, output ready);
endinterface

// ----- design/fse_out_if.sv -----
// Result channel carrying emitted characters.
interface fse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last_of_run;
  logic [31:0] emitted_count;
  modport source (output valid, out_char, last_of_run, emitted_count, input ready);
  modport sink (input valid, out_char, last_of_run, emitted_count, output ready);
endinterface

// ----- design/fse_datapath.sv -----
// Datapath: pattern decoding, literal queue, digit conversion and output register.
module fse_datapath import fse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             command,
  input  logic [7:0]       pattern_byte,
  input  logic [ARG_W-1:0] argument_value,
  input  fse_cmd_t         cmd,
  output fse_stat_t        stat,
  output logic [7:0]       out_char,
  output logic             last_of_run,
  output logic [31:0]      emitted_count
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_PCT, MODE_PCT_L} mode_t;

  mode_t            parse_mode, mode_next;
  logic [31:0]      char_count;
  logic [7:0]       lit [LIT_N];
  logic [LITC_W-1:0] lit_cnt;
  logic             num, hex, upper, clear_after;
  logic [ARG_W-1:0] value;
  logic [3:0]       digit_store [MAX_DIGITS];
  logic [IDX_W-1:0] idx;
  logic [STEP_W-1:0] step;

  logic [7:0]       d_lit [LIT_N];
  logic [LITC_W-1:0] d_cnt;
  logic             d_num, d_hex, d_up, d_clr, is_long, neg;
  logic [ARG_W-1:0] d_val;
  logic [4*MAX_DIGITS-1:0] d_wide;
  logic [31:0]      w_neg;
  logic [3:0]       adj [MAX_DIGITS];

  always_comb begin
    d_lit[0] = 8'd0;
    d_lit[1] = 8'd0;
    d_lit[2] = 8'd0;
    d_cnt = '0;
    d_num = 1'b0;
    d_hex = 1'b0;
    d_up = 1'b0;
    d_clr = 1'b0;
    d_val = argument_value;
    mode_next = MODE_IDLE;
    is_long = (parse_mode == MODE_PCT_L);
    neg = 1'b0;
    w_neg = 32'd0 - argument_value[31:0];
    if (command == CMD_END || pattern_byte == 8'd0) begin
      d_clr = 1'b1;
      if (parse_mode == MODE_PCT) begin
        d_lit[0] = CH_PCT;
        d_cnt = 2'd1;
      end else if (parse_mode == MODE_PCT_L) begin
        d_lit[0] = CH_PCT;
        d_lit[1] = CH_L;
        d_cnt = 2'd2;
      end
    end else if (parse_mode == MODE_PCT && pattern_byte == CH_L) begin
      mode_next = MODE_PCT_L;
    end else if (parse_mode == MODE_PCT || parse_mode == MODE_PCT_L) begin
      if (!is_long && pattern_byte == CH_PCT) begin
        d_lit[0] = CH_PCT;
        d_cnt = 2'd1;
      end else if (!is_long && pattern_byte == CH_C) begin
        d_lit[0] = argument_value[7:0];
        d_cnt = 2'd1;
      end else if (!is_long && pattern_byte == CH_S) begin
        d_lit[0] = CH_PCT;
        d_lit[1] = CH_S;
        d_cnt = 2'd2;
      end else if (!is_long && pattern_byte == CH_P) begin
        d_lit[0] = CH_ZERO;
        d_lit[1] = CH_X;
        d_cnt = 2'd2;
        d_num = 1'b1;
        d_hex = 1'b1;
      end else if (pattern_byte == CH_D || pattern_byte == CH_I) begin
        d_num = 1'b1;
        if (is_long) begin
          neg = argument_value[ARG_W-1];
          d_val = neg ? ('0 - argument_value) : argument_value;
        end else begin
          neg = argument_value[31];
          d_val = {32'd0, neg ? w_neg : argument_value[31:0]};
        end
        if (neg) begin
          d_lit[0] = CH_MINUS;
          d_cnt = 2'd1;
        end
      end else if (pattern_byte == CH_U || pattern_byte == CH_X || pattern_byte == CH_UX) begin
        d_num = 1'b1;
        d_val = is_long ? argument_value : {32'd0, argument_value[31:0]};
        d_hex = (pattern_byte != CH_U);
        d_up = (pattern_byte == CH_UX);
      end else begin
        d_lit[0] = CH_PCT;
        if (is_long) begin
          d_lit[1] = CH_L;
          d_lit[2] = pattern_byte;
          d_cnt = 2'd3;
        end else begin
          d_lit[1] = pattern_byte;
          d_cnt = 2'd2;
        end
      end
    end else if (pattern_byte == CH_PCT) begin
      mode_next = MODE_PCT;
    end else begin
      d_lit[0] = pattern_byte;
      d_cnt = 2'd1;
    end
  end

  // The argument widened to the full digit store, so every digit has a nibble.
  assign d_wide = {{(4*MAX_DIGITS-ARG_W){1'b0}}, d_val};

  // Double-dabble correction of each decimal digit before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit_store[i] >= 4'd5) ? digit_store[i] + 4'd3 : digit_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_IDLE;
      char_count <= 32'd0;
      lit_cnt <= '0;
      num <= 1'b0;
    end else begin
      if (cmd.load) begin
        parse_mode <= mode_next;
        lit <= d_lit;
        lit_cnt <= d_cnt;
        num <= d_num;
        hex <= d_hex;
        upper <= d_up;
        clear_after <= d_clr;
        value <= d_val;
        idx <= IDX_W'(MAX_DIGITS - 1);
        step <= '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          digit_store[i] <= d_hex ? d_wide[4*i +: 4] : 4'd0;
        end
      end
      if (cmd.dabble) begin
        value <= {value[ARG_W-2:0], 1'b0};
        step <= step + 1'b1;
        digit_store[0] <= {adj[0][2:0], value[ARG_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
          digit_store[i] <= {adj[i][2:0], adj[i-1][3]};
        end
      end
      if (cmd.skip || (cmd.emit && cmd.sel_digit && !stat.idx_zero)) begin
        idx <= idx - 1'b1;
      end
      if (cmd.emit) begin
        out_char <= cmd.sel_digit ? digit_char(digit_store[idx], upper) : lit[0];
        last_of_run <= cmd.last;
        emitted_count <= char_count + 32'd1;
        if (!cmd.sel_digit) begin
          lit[0] <= lit[1];
          lit[1] <= lit[2];
          lit_cnt <= lit_cnt - 1'b1;
        end
      end
      if (cmd.finish && clear_after) begin
        char_count <= 32'd0;
      end else if (cmd.emit) begin
        char_count <= char_count + 32'd1;
      end
    end
  end

  assign stat.lit_left   = (lit_cnt != '0);
  assign stat.lit_one    = (lit_cnt == LITC_W'(1));
  assign stat.num        = num;
  assign stat.hex        = hex;
  assign stat.dab_done   = &step;
  assign stat.digit_zero = (digit_store[idx] == 4'd0);
  assign stat.idx_zero   = (idx == '0);

endmodule

// ----- design/fse_ctrl.sv -----
// Controller: sequences literal output, digit conversion and digit output.
module fse_ctrl import fse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fse_stat_t stat,
  output fse_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_LIT, S_DAB, S_SCAN, S_DIG} state_t;

  state_t state, state_next;
  logic   can_emit;

  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LIT;
        end
      end
      S_LIT: begin
        if (stat.lit_left) begin
          if (can_emit) begin
            cmd.emit = 1'b1;
            cmd.last = stat.lit_one && !stat.num;
            if (cmd.last) begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
        end else if (stat.num) begin
          state_next = stat.hex ? S_SCAN : S_DAB;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DAB: begin
        cmd.dabble = 1'b1;
        if (stat.dab_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.digit_zero && !stat.idx_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        if (can_emit) begin
          cmd.emit = 1'b1;
          cmd.sel_digit = 1'b1;
          cmd.last = stat.idx_zero;
          if (stat.idx_zero) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/format_string_expander.sv -----
// Top level of the printf-style format string expander.
// Requests arrive on the item channel: each carries a command (pattern byte
// or end of pattern), a pattern byte and a 64-bit argument word. Formatted
// characters leave on the result channel, one per request on that channel,
// each with a running count, and the final character caused by an item is
// marked with last_of_run. An item that causes no character gives nothing.
// The block handles one item at a time. An ordinary byte is loaded into the
// literal queue when it is accepted and moves on into the output register
// once the receiver can take it; only then can the next item be accepted.
// A conversion first gives out its literals; a decimal conversion then
// runs a shift-and-add-three binary to decimal pass. Every conversion then
// skips the leading zero digits, finds the first digit and emits the
// digits in turn. The output register lets a new item be accepted while
// the last character of the previous item still waits for the receiver.
// When the receiver stalls, the character and its count are held and no
// further character is emitted, though a binary to decimal pass or a
// zero-digit scan already under way goes on.
// Reset (synchronous, active high) returns the parser to its idle mode,
// clears the count and empties the output register.
module format_string_expander import fse_pkg::*; (
  input logic      clk,
  input logic      rst,
  fse_in_if.sink   item,
  fse_out_if.source result
);

  fse_cmd_t  cmd;
  fse_stat_t stat;

  // The controller owns the handshakes; the datapath owns all payload state.
  fse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fse_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .command        (item.command),
    .pattern_byte   (item.pattern_byte),
    .argument_value (item.argument_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_char       (result.out_char),
    .last_of_run    (result.last_of_run),
    .emitted_count  (result.emitted_count)
  );

endmodule

// ----- design/fse_checker.sv -----
// Port-level checker of the format string expander and its bind.
`include "format_string_expander_assert.svh"
module fse_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        out_last,
  input logic [31:0] out_count
);

  logic        run_open;
  logic [31:0] prev_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
    end else if (out_valid && out_ready) begin
      run_open <= !out_last;
      prev_count <= out_count;
    end
  end

  // Within a run the block takes a new item only once the run's last
  // character sits in the output register.
  `FSE_ASSERT_NOW(a_no_item_mid_run, run_open && in_ready, out_valid && out_last,
    "item accepted inside a run")
  `FSE_ASSERT_NOW(a_count_steps, out_valid && run_open, out_count == prev_count + 32'd1,
    "count did not advance by one within a run")
  `FSE_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
    out_valid && $stable(out_char) && $stable(out_count), "stalled result changed")

endmodule

bind format_string_expander fse_port_checker u_fse_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_char  (result.out_char),
  .out_last  (result.last_of_run),
  .out_count (result.emitted_count)
);
